FILE: rtl/twhc_pkg.sv
// Shared types and constants for the two-way hashed result cache.
`default_nettype none

package twhc_pkg;

	localparam int KEY_W = 64;
	localparam int PAYLOAD_W = 64;
	localparam int AGE_W = 8;

	// Golden-ratio multiplier for the set hash, split in halves for the partial products
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] HASH_LO = HASH_MULT[31:0];
	localparam logic [31:0] HASH_HI = HASH_MULT[63:32];

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FILL = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef struct packed {
		logic cmd;
		logic [KEY_W-1:0] lookup_key;
		logic [PAYLOAD_W-1:0] fill_payload;
	} twhc_req_t;

	typedef struct packed {
		logic hit;
		logic [PAYLOAD_W-1:0] hit_payload;
	} twhc_rsp_t;

	typedef enum logic {
		MODE_CLEAR,
		MODE_RUN
	} twhc_mode_t;

endpackage

`default_nettype wire

FILE: rtl/twhc_front.sv
// Front end: accept items, hash the key and reduce it to a set index.
`default_nettype none

module twhc_front #(
	parameter int SET_COUNT = 1024,
	parameter int IDX_W = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire twhc_pkg::twhc_req_t in_item,
	output logic                    in_stall,
	output logic                    push,
	output twhc_pkg::twhc_req_t     push_item,
	output logic [IDX_W-1:0]        push_set,
	input  wire logic               queue_full
);

	localparam bit IS_POW2 = (SET_COUNT & (SET_COUNT - 1)) == 0;

	logic                 en;
	logic                 v_s1, v_s2, v_s3;
	twhc_pkg::twhc_req_t  item_s1, item_s2, item_s3;
	logic [63:0]          p_lo_s1, p_lo_s2;
	logic [31:0]          x1_s1, x1_s2, x2_s2;
	logic [63:0]          mixed_s3;
	logic                 set_ready;

	assign en = !v_s3 || push;
	assign in_stall = !en;
	assign push = v_s3 && set_ready && !queue_full;
	assign push_item = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Low 64 bits of key * HASH_MULT from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			p_lo_s1 <= 64'(in_item.lookup_key[31:0]) * 64'(twhc_pkg::HASH_LO);
			x1_s1 <= in_item.lookup_key[63:32] * twhc_pkg::HASH_LO;
			item_s2 <= item_s1;
			p_lo_s2 <= p_lo_s1;
			x1_s2 <= x1_s1;
			x2_s2 <= item_s1.lookup_key[31:0] * twhc_pkg::HASH_HI;
			item_s3 <= item_s2;
			mixed_s3 <= p_lo_s2 + {x1_s2 + x2_s2, 32'b0};
		end
	end

	generate
		if (IS_POW2) begin : g_mask
			assign set_ready = 1'b1;
			assign push_set = mixed_s3[IDX_W-1:0];
		end else begin : g_rem
			// Remainder by SET_COUNT, four bits of the hash a cycle from the top
			localparam int DIGIT_W = 4;
			localparam int STEPS = 64 / DIGIT_W;
			localparam int CNT_W = $clog2(STEPS) + 1;
			localparam logic [IDX_W:0] SET_N = (IDX_W + 1)'(SET_COUNT);

			logic [CNT_W-1:0]   cnt_q;
			logic [IDX_W-1:0]   rem_q;
			logic [IDX_W-1:0]   rem_next;
			logic [DIGIT_W-1:0] digit;
			logic [IDX_W:0]     t;

			assign set_ready = cnt_q == CNT_W'(STEPS);
			assign push_set = rem_q;
			assign digit = mixed_s3[(63 - DIGIT_W * cnt_q[CNT_W-2:0]) -: DIGIT_W];

			always_comb begin
				rem_next = rem_q;
				t = '0;
				for (int i = 0; i < DIGIT_W; i++) begin
					t = {rem_next, digit[DIGIT_W-1-i]};
					if (t >= SET_N) t = t - SET_N;
					rem_next = t[IDX_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
					rem_q <= '0;
				end else if (en) begin
					cnt_q <= '0;
					rem_q <= '0;
				end else if (!set_ready) begin
					cnt_q <= cnt_q + 1'b1;
					rem_q <= rem_next;
				end
			end
		end
	endgenerate

endmodule

`default_nettype wire

FILE: rtl/twhc_queue.sv
// Short queue between the front end and the back end.
`default_nettype none

module twhc_queue #(
	parameter int IDX_W = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire twhc_pkg::twhc_req_t push_item,
	input  wire logic [IDX_W-1:0]    push_set,
	output logic                     full,
	output logic                     head_valid,
	output twhc_pkg::twhc_req_t      head_item,
	output logic [IDX_W-1:0]         head_set,
	input  wire logic                pop
);

	twhc_pkg::twhc_req_t              item_q [twhc_pkg::QUEUE_DEPTH];
	logic [IDX_W-1:0]                 set_q [twhc_pkg::QUEUE_DEPTH];
	logic [twhc_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [twhc_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full = count_q == twhc_pkg::QUEUE_CNT_W'(twhc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item = item_q[rd_ptr_q];
	assign head_set = set_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= push_item;
			set_q[wr_ptr_q] <= push_set;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/twhc_back.sv
// Back end: set memories, hit and victim logic, age stamping and result register.
`default_nettype none

module twhc_back #(
	parameter int SET_COUNT = 1024,
	parameter int WAY_COUNT = 2,
	parameter int IDX_W = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire twhc_pkg::twhc_req_t head_item,
	input  wire logic [IDX_W-1:0]    head_set,
	output logic                     pop,
	output logic                     clearing,
	output logic                     rsp_valid,
	output twhc_pkg::twhc_rsp_t      rsp,
	input  wire logic                rsp_stall
);

	localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int KW = twhc_pkg::KEY_W;
	localparam int PW = twhc_pkg::PAYLOAD_W;
	localparam int AW = twhc_pkg::AGE_W;

	// Set memories, one row per set
	logic [WAY_COUNT-1:0][KW-1:0] tag_mem [SET_COUNT];
	logic [WAY_COUNT-1:0][PW-1:0] pay_mem [SET_COUNT];
	logic [WAY_COUNT-1:0]         vld_mem [SET_COUNT];
	logic [WAY_COUNT-1:0][AW-1:0] age_mem [SET_COUNT];

	twhc_pkg::twhc_mode_t mode_q, mode_d;
	logic [IDX_W-1:0]     clr_q, clr_d;

	logic                         v_s1, fwd_meta_s1, fwd_data_s1;
	twhc_pkg::twhc_req_t          item_s1;
	logic [IDX_W-1:0]             set_s1;
	logic [WAY_COUNT-1:0][KW-1:0] rd_tag_s1;
	logic [WAY_COUNT-1:0][PW-1:0] rd_pay_s1;
	logic [WAY_COUNT-1:0]         rd_vld_s1;
	logic [WAY_COUNT-1:0][AW-1:0] rd_age_s1;

	logic [WAY_COUNT-1:0][KW-1:0] wr_tag_q;
	logic [WAY_COUNT-1:0][PW-1:0] wr_pay_q;
	logic [WAY_COUNT-1:0]         wr_vld_q;
	logic [WAY_COUNT-1:0][AW-1:0] wr_age_q;

	logic [AW-1:0]       use_clk_q;
	logic                rsp_valid_q;
	twhc_pkg::twhc_rsp_t rsp_q;

	logic [WAY_COUNT-1:0][KW-1:0] cur_tag, new_tag;
	logic [WAY_COUNT-1:0][PW-1:0] cur_pay, new_pay;
	logic [WAY_COUNT-1:0]         cur_vld, new_vld;
	logic [WAY_COUNT-1:0][AW-1:0] cur_age, new_age;

	logic             is_fill, rsp_free, b_go, issue, wr_meta, wr_data;
	logic             hit, found_inv;
	logic [WAY_W-1:0] hit_way, vic_way;
	logic [AW-1:0]    vic_age, stamp;

	assign clearing = mode_q == twhc_pkg::MODE_CLEAR;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Clear pass over the valid bits after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= twhc_pkg::MODE_CLEAR;
			clr_q <= '0;
		end else begin
			mode_q <= mode_d;
			clr_q <= clr_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		clr_d = clr_q;
		unique case (mode_q)
			twhc_pkg::MODE_CLEAR: begin
				clr_d = clr_q + 1'b1;
				if (clr_q == IDX_W'(SET_COUNT - 1)) mode_d = twhc_pkg::MODE_RUN;
			end
			twhc_pkg::MODE_RUN: begin
				clr_d = clr_q;
			end
			default: begin
				mode_d = twhc_pkg::MODE_CLEAR;
			end
		endcase
	end

	assign is_fill = item_s1.cmd == twhc_pkg::CMD_FILL;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign b_go = v_s1 && (is_fill || rsp_free);
	assign issue = !clearing && head_valid && (!v_s1 || b_go);
	assign pop = issue;

	// Take the row just written when the read raced that write
	assign cur_tag = fwd_data_s1 ? wr_tag_q : rd_tag_s1;
	assign cur_pay = fwd_data_s1 ? wr_pay_q : rd_pay_s1;
	assign cur_vld = fwd_meta_s1 ? wr_vld_q : rd_vld_s1;
	assign cur_age = fwd_meta_s1 ? wr_age_q : rd_age_s1;

	assign stamp = use_clk_q + 1'b1;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!hit && cur_vld[w] && cur_tag[w] == item_s1.lookup_key) begin
				hit = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// Victim: first invalid way, else strictly oldest, earlier way on ties
	always_comb begin
		found_inv = 1'b0;
		vic_way = '0;
		vic_age = cur_age[0];
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!found_inv) begin
				if (!cur_vld[w]) begin
					found_inv = 1'b1;
					vic_way = WAY_W'(w);
				end else if (cur_age[w] < vic_age) begin
					vic_way = WAY_W'(w);
					vic_age = cur_age[w];
				end
			end
		end
	end

	always_comb begin
		new_tag = cur_tag;
		new_pay = cur_pay;
		new_vld = cur_vld;
		new_age = cur_age;
		if (is_fill) begin
			new_tag[vic_way] = item_s1.lookup_key;
			new_pay[vic_way] = item_s1.fill_payload;
			new_vld[vic_way] = 1'b1;
			new_age[vic_way] = stamp;
		end else begin
			new_age[hit_way] = stamp;
		end
	end

	assign wr_meta = b_go && (is_fill || hit);
	assign wr_data = b_go && is_fill;

	always_ff @(posedge clk) begin
		if (clearing) begin
			vld_mem[clr_q] <= '0;
		end else if (wr_meta) begin
			vld_mem[set_s1] <= new_vld;
			age_mem[set_s1] <= new_age;
		end
		if (wr_data) begin
			tag_mem[set_s1] <= new_tag;
			pay_mem[set_s1] <= new_pay;
		end
		if (issue) begin
			rd_tag_s1 <= tag_mem[head_set];
			rd_pay_s1 <= pay_mem[head_set];
			rd_vld_s1 <= vld_mem[head_set];
			rd_age_s1 <= age_mem[head_set];
			item_s1 <= head_item;
			set_s1 <= head_set;
		end
		if (wr_meta) begin
			wr_vld_q <= new_vld;
			wr_age_q <= new_age;
		end
		if (wr_data) begin
			wr_tag_q <= new_tag;
			wr_pay_q <= new_pay;
		end
		if (b_go && !is_fill) begin
			rsp_q.hit <= hit;
			rsp_q.hit_payload <= hit ? cur_pay[hit_way] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_meta_s1 <= 1'b0;
			fwd_data_s1 <= 1'b0;
			use_clk_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				v_s1 <= 1'b1;
				fwd_meta_s1 <= wr_meta && set_s1 == head_set;
				fwd_data_s1 <= wr_data && set_s1 == head_set;
			end else if (b_go) begin
				v_s1 <= 1'b0;
			end
			if (wr_meta) use_clk_q <= stamp;
			if (b_go && !is_fill) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/two_way_hashed_cache_age_replace.sv
// Top level of the hashed set-associative result cache with age-stamp replacement.
`default_nettype none

// Set-associative result cache keyed by a 64-bit hash. Each transfer on req is a
// lookup (cmd 0) or a fill (cmd 1); a lookup yields one transfer on rsp with hit and
// the stored payload (zero on a miss), a fill yields none. The set is the low 64 bits
// of key times the golden-ratio constant, reduced modulo SET_COUNT. Hits and fills
// stamp the touched way with a pre-incremented, wrapping 8-bit use clock; a fill
// replaces the first invalid way, else the way with the strictly lowest age.
// After reset the block clears its valid bits, one set per cycle, and holds req
// stalled meanwhile. With SET_COUNT a power of two the block sustains one item per
// cycle while rsp is not stalled: the front end is a three-stage hash multiplier and
// the back end registers the set row it reads and writes it back from that stage, with
// forwarding between back-to-back items of the same set. A lookup's result is registered
// after the hash stages, the queue and the back-end read stage. For other SET_COUNT
// values the remainder unit takes four hash bits a cycle and the front end waits for it.
// A short queue between front and back lets each side stall on its own.
module two_way_hashed_cache_age_replace #(
	parameter int SET_COUNT = 1024,
	parameter int WAY_COUNT = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire twhc_pkg::twhc_req_t req,
	output logic                     req_stall,
	output logic                     rsp_valid,
	output twhc_pkg::twhc_rsp_t      rsp,
	input  wire logic                rsp_stall
);

	localparam int IDX_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

	logic                front_stall;
	logic                clearing;
	logic                push, queue_full;
	twhc_pkg::twhc_req_t push_item, head_item;
	logic [IDX_W-1:0]    push_set, head_set;
	logic                head_valid, pop;

	// Hold req off while the valid bits are being cleared
	assign req_stall = front_stall || clearing;

	twhc_front #(
		.SET_COUNT(SET_COUNT),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_valid && !clearing),
		.in_item(req),
		.in_stall(front_stall),
		.push(push),
		.push_item(push_item),
		.push_set(push_set),
		.queue_full(queue_full)
	);

	twhc_queue #(
		.IDX_W(IDX_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.push_set(push_set),
		.full(queue_full),
		.head_valid(head_valid),
		.head_item(head_item),
		.head_set(head_set),
		.pop(pop)
	);

	twhc_back #(
		.SET_COUNT(SET_COUNT),
		.WAY_COUNT(WAY_COUNT),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_item(head_item),
		.head_set(head_set),
		.pop(pop),
		.clearing(clearing),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall)
	);

endmodule

`default_nettype wire

FILE: test/twhc_checker.sv
// Checker for the hashed result cache: predicts lookup results and compares each transfer.
`default_nettype none

module twhc_checker
	import twhc_pkg::*;
#(
	parameter int SET_COUNT = 1024,
	parameter int WAY_COUNT = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire twhc_req_t  req,
	input  wire logic       req_stall,
	input  wire logic       rsp_valid,
	input  wire twhc_rsp_t  rsp,
	input  wire logic       rsp_stall,
	output int              errors,
	output int              outstanding,
	output int              results_seen,
	output int              hits_seen
);

	localparam int ENTRIES = SET_COUNT * WAY_COUNT;
	localparam int REPORT_CAP = 20;

	logic [KEY_W-1:0] tag_mem [ENTRIES];
	logic [PAYLOAD_W-1:0] payload_mem [ENTRIES];
	logic valid_mem [ENTRIES];
	logic [AGE_W-1:0] age_mem [ENTRIES];
	logic [AGE_W-1:0] use_clock;
	twhc_rsp_t pending_lookups[$];
	twhc_rsp_t due;

	initial begin
		errors = 0;
		results_seen = 0;
		hits_seen = 0;
	end

	task automatic report_error(input string msg);
		if (errors < REPORT_CAP)
			$display("checker: %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic int set_base(input logic [KEY_W-1:0] key);
		logic [63:0] mixed;
		mixed = key * HASH_MULT;
		return int'(mixed % 64'(SET_COUNT)) * WAY_COUNT;
	endfunction

	function automatic logic [AGE_W-1:0] next_stamp();
		use_clock = use_clock + 1'b1;
		return use_clock;
	endfunction

	// Update the cache image for one accepted request; queue the result of a lookup.
	task automatic cache_access(input twhc_req_t r);
		int base;
		int slot;
		int victim;
		bit found;
		twhc_rsp_t result;
		base = set_base(r.lookup_key);
		found = 1'b0;
		if (r.cmd == CMD_LOOKUP) begin
			result = '0;
			for (int w = 0; w < WAY_COUNT; w++) begin
				slot = base + w;
				if (!found && valid_mem[slot] && tag_mem[slot] == r.lookup_key) begin
					found = 1'b1;
					result.hit = 1'b1;
					result.hit_payload = payload_mem[slot];
					age_mem[slot] = next_stamp();
				end
			end
			pending_lookups.push_back(result);
		end else begin
			// first invalid way wins; otherwise strictly lowest age, ties keep the earlier way
			victim = base;
			for (int w = 0; w < WAY_COUNT; w++) begin
				slot = base + w;
				if (!found) begin
					if (!valid_mem[slot]) begin
						victim = slot;
						found = 1'b1;
					end else if (age_mem[slot] < age_mem[victim]) begin
						victim = slot;
					end
				end
			end
			tag_mem[victim] = r.lookup_key;
			payload_mem[victim] = r.fill_payload;
			valid_mem[victim] = 1'b1;
			age_mem[victim] = next_stamp();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (valid_mem[i]) begin
				valid_mem[i] = 1'b0;
				age_mem[i] = '0;
			end
			use_clock = '0;
			pending_lookups.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (pending_lookups.size() == 0) begin
					report_error($sformatf("result with no lookup waiting: hit %b payload %h",
						rsp.hit, rsp.hit_payload));
				end else begin
					due = pending_lookups.pop_front();
					if (rsp.hit !== due.hit)
						report_error($sformatf("result %0d hit: got %b, expected %b",
							results_seen, rsp.hit, due.hit));
					if (rsp.hit_payload !== due.hit_payload)
						report_error($sformatf("result %0d hit_payload: got %h, expected %h",
							results_seen, rsp.hit_payload, due.hit_payload));
					if (due.hit)
						hits_seen++;
				end
			end
			if (req_valid && !req_stall)
				cache_access(req);
			outstanding <= pending_lookups.size();
		end
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Top of the cache testbench: clock, reset, request and stall stimulus, and the verdict.
`default_nettype none

module testbench;
	import twhc_pkg::*;

	localparam int SET_COUNT = 1024;
	localparam int WAY_COUNT = 2;
	// Run-length bound, far above what a correct run needs (clearing pass included).
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 400;
	localparam int PHASE1_START = 130;
	localparam int PHASE2_START = 260;
	localparam int TIE_START = 300;
	localparam int POOL_SIZE = 16;
	localparam int HOT_SETS = 6;
	localparam logic [9:0] TIE_LOW = 10'h2AA;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	twhc_req_t req = '0;
	logic req_stall;
	logic rsp_valid;
	twhc_rsp_t rsp;
	logic rsp_stall = 1'b0;

	int errors;
	int outstanding;
	int results_seen;
	int hits_seen;

	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int lookups_sent = 0;
	int fills_sent = 0;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	logic [9:0] hot_lows [HOT_SETS] = '{10'h011, 10'h0F0, 10'h155, 10'h1C3, 10'h23E, 10'h3FF};

	two_way_hashed_cache_age_replace #(
		.SET_COUNT(SET_COUNT),
		.WAY_COUNT(WAY_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall)
	);

	twhc_checker #(
		.SET_COUNT(SET_COUNT),
		.WAY_COUNT(WAY_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall),
		.errors(errors),
		.outstanding(outstanding),
		.results_seen(results_seen),
		.hits_seen(hits_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: timeout after %0d cycles", cycle_count);
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Result-side stall. The long hold counts its own cycles so the sender can keep
	// pushing; the block's queue fills and it must stall its request side.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_go && !long_hold_done) begin
			rsp_stall <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			long_hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// Offer one request after a random gap; hold it until the transfer happens.
	// Valid stays high on return so a back-to-back request does not drop it.
	task automatic send_req(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [PAYLOAD_W-1:0] payload);
		twhc_req_t item;
		item.cmd = cmd;
		item.lookup_key = key;
		item.fill_payload = payload;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (cmd == CMD_LOOKUP)
			lookups_sent++;
		else
			fills_sent++;
	endtask

	// Drop valid and hold off until every predicted result has been seen.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	function automatic logic [KEY_W-1:0] key_in_set(input logic [9:0] low);
		logic [KEY_W-1:0] key;
		key = {$urandom, $urandom};
		key[9:0] = low;
		return key;
	endfunction

	// Fully random key, kept out of the set reserved for the age-tie sequence.
	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] key;
		key = {$urandom, $urandom};
		if (key[9:0] == TIE_LOW)
			key[0] = ~key[0];
		return key;
	endfunction

	initial begin
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [KEY_W-1:0] key_c;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] tie_old;
		logic [KEY_W-1:0] tie_new;
		logic [KEY_W-1:0] tie_late;
		logic cmd;

		key_a = 64'h0123_4567_89AB_C155;
		key_b = 64'hFEDC_BA98_7654_3155;
		key_c = 64'h8000_0000_0000_0155;
		foreach (key_pool[i])
			key_pool[i] = key_in_set(hot_lows[i % HOT_SETS]);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(29, 66);

		// Directed: misses on an empty cache, key extremes, fill into free ways,
		// eviction of the older way, duplicate fill, same set with a foreign tag.
		send_req(CMD_LOOKUP, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		send_req(CMD_FILL, key_a, 64'hFFFF_FFFF_FFFF_FFFF);
		send_req(CMD_LOOKUP, key_a, 64'h0);
		send_req(CMD_FILL, key_b, 64'h0);
		send_req(CMD_LOOKUP, key_b, 64'h0);
		send_req(CMD_LOOKUP, key_a, 64'h0);
		// both ways valid, key_b is older: it goes
		send_req(CMD_FILL, key_c, 64'hA5A5_A5A5_A5A5_A5A5);
		send_req(CMD_LOOKUP, key_b, 64'h0);
		send_req(CMD_LOOKUP, key_c, 64'h0);
		send_req(CMD_LOOKUP, key_a, 64'h0);
		// second copy of key_a lands on key_c's way; lookup returns the lower way
		send_req(CMD_FILL, key_a, 64'h5A5A_5A5A_5A5A_5A5A);
		send_req(CMD_LOOKUP, key_a, 64'h0);
		send_req(CMD_LOOKUP, key_c, 64'h0);
		send_req(CMD_FILL, 64'h0, 64'h0000_0000_0000_0001);
		send_req(CMD_LOOKUP, 64'h0, 64'h0);
		send_req(CMD_FILL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
		send_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		send_req(CMD_LOOKUP, 64'h0000_0000_0000_0155, 64'h0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PHASE1_START) begin
				wait_drained();
				set_idling(66, 29);
			end
			if (n == PHASE2_START) begin
				wait_drained();
				set_idling(0, 0);
				long_hold_go <= 1'b1;
			end
			if (n == TIE_START) begin
				// Age tie after clock wrap: two fills, then 255 hits on the newer way
				// bring its stamp round to the older way's value; the next fill must
				// evict the lower way.
				tie_old = key_in_set(TIE_LOW);
				tie_new = key_in_set(TIE_LOW);
				tie_late = key_in_set(TIE_LOW);
				send_req(CMD_FILL, tie_old, {$urandom, $urandom});
				send_req(CMD_FILL, tie_new, {$urandom, $urandom});
				repeat (255)
					send_req(CMD_LOOKUP, tie_new, {$urandom, $urandom});
				send_req(CMD_FILL, tie_late, {$urandom, $urandom});
				send_req(CMD_LOOKUP, tie_old, {$urandom, $urandom});
				send_req(CMD_LOOKUP, tie_new, {$urandom, $urandom});
				send_req(CMD_LOOKUP, tie_late, {$urandom, $urandom});
			end

			// Mostly keys that crowd a few sets, so hits and evictions are common.
			if ($urandom_range(0, 99) < 5)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] =
					key_in_set(hot_lows[$urandom_range(0, HOT_SETS - 1)]);
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				key = random_key();
			cmd = ($urandom_range(0, 99) < 45) ? CMD_FILL : CMD_LOOKUP;
			send_req(cmd, key, {$urandom, $urandom});
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("testbench: %0d lookups and %0d fills sent, %0d results checked, %0d hits",
			lookups_sent, fills_sent, results_seen, hits_seen);
		$display("testbench: covered misses, hits, age eviction, duplicate fills, %s",
			"an age tie after clock wrap and a long result-side hold");
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
